// ===== src/ssft_pkg.sv =====
`default_nettype none
package ssft_pkg;

	localparam int MAX_STEPS  = 64;
	localparam int VALUE_BITS = 32;
	localparam int IDX_W      = $clog2(MAX_STEPS);
	localparam int CNT_W      = 7;
	localparam int OP_W       = 3;
	localparam int STAT_W     = 2;

	localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam logic signed [VALUE_BITS-1:0] VAL_MIN = ~VAL_MAX;

	typedef logic [2*VALUE_BITS-1:0] entry_t;  // {x, y}

	typedef enum logic [OP_W-1:0] {
		OP_CREATE    = 3'd0,
		OP_INSERT    = 3'd1,
		OP_DELETE    = 3'd2,
		OP_EVALUATE  = 3'd3,
		OP_MINIMUM   = 3'd4,
		OP_MAXIMUM   = 3'd5,
		OP_TRANSLATE = 3'd6
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_MISS  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_FINISH,
		S_DONE
	} state_t;

	// saturating signed add
	function automatic logic signed [VALUE_BITS-1:0] sat_add(
		input logic signed [VALUE_BITS-1:0] a,
		input logic signed [VALUE_BITS-1:0] b
	);
		logic [VALUE_BITS:0] s;
		s = {a[VALUE_BITS-1], a} + {b[VALUE_BITS-1], b};
		if (s[VALUE_BITS] != s[VALUE_BITS-1]) begin
			return s[VALUE_BITS] ? VAL_MIN : VAL_MAX;
		end
		return s[VALUE_BITS-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== src/ssft_if.sv =====
`default_nettype none
interface ssft_cmd_if import ssft_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic [OP_W-1:0]               op;
	logic signed [VALUE_BITS-1:0]  x_value;
	logic signed [VALUE_BITS-1:0]  y_value;

	modport source (output valid, op, x_value, y_value, input ready);
	modport sink   (input valid, op, x_value, y_value, output ready);
endinterface

interface ssft_rsp_if import ssft_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_BITS-1:0]  value;
	logic [STAT_W-1:0]             status;
	logic [CNT_W-1:0]              entry_count;

	modport source (output valid, value, status, entry_count, input ready);
	modport sink   (input valid, value, status, entry_count, output ready);
endinterface
`default_nettype wire

// ===== src/sorted_step_function_table_unit.sv =====
`default_nettype none
// Sorted step-function table. Holds up to MAX_STEPS breakpoints (x, y), signed 16.16,
// in ascending x order in a single 64-entry memory, and answers every command
// transaction with exactly one response transaction (value, status, entry_count).
// Commands: create, insert, delete, evaluate, minimum, maximum, translate; op 7 is a
// no-op that reports ok. Every command except create and the no-op walks the stored
// breakpoints one per cycle through the memory read port, with one compare/add unit
// doing the work on each entry, shifting entries in the same pass for insert and
// delete. A command goes from idle through the walk and finish states to done, where its
// response waits for the output register; create skips the walk, and the no-op and the
// other commands on an empty table go straight from idle to done.
// Insert stops early on an exact x match or a full table.
// cmd.ready is high only while the sequencer is idle; a finished response sits in an
// output register, so the next command is accepted while it waits to be taken.
// Memory contents are undefined after reset; only entries below the count are read.
module sorted_step_function_table_unit import ssft_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	ssft_cmd_if.sink   cmd,
	ssft_rsp_if.source rsp
);

	// breakpoint memory, {x, y} per word
	entry_t mem [MAX_STEPS];
	entry_t rdata_q;

	state_t                       state_q, state_d;
	op_t                          op_q, op_d;
	logic signed [VALUE_BITS-1:0] xv_q, xv_d, yv_q, yv_d;
	logic [CNT_W-1:0]             n_q, n_d;          // stored breakpoints
	logic [CNT_W-1:0]             rd_ptr_q, rd_ptr_d; // next read address
	logic [IDX_W-1:0]             proc_q, proc_d;     // address of rdata_q
	logic                         pend_q, pend_d;     // rdata_q holds a fresh entry
	logic                         found_q, found_d;   // insert/delete in shift phase, eval hit
	entry_t                       carry_q, carry_d;   // entry pushed down by insert
	logic signed [VALUE_BITS-1:0] res_q, res_d;
	status_t                      stat_q, stat_d;

	logic                         rsp_valid_q;
	logic signed [VALUE_BITS-1:0] value_q;
	status_t                      status_q;
	logic [CNT_W-1:0]             count_q;
	logic                         out_load;

	logic                         we;
	logic [IDX_W-1:0]             waddr;
	entry_t                       wdata;

	logic signed [VALUE_BITS-1:0] dx, dy;

	assign dx = rdata_q[2*VALUE_BITS-1:VALUE_BITS];
	assign dy = rdata_q[VALUE_BITS-1:0];

	// memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[rd_ptr_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			n_q         <= '0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			n_q     <= n_d;
			pend_q  <= pend_d;
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q     <= op_d;
		xv_q     <= xv_d;
		yv_q     <= yv_d;
		rd_ptr_q <= rd_ptr_d;
		proc_q   <= proc_d;
		found_q  <= found_d;
		carry_q  <= carry_d;
		res_q    <= res_d;
		stat_q   <= stat_d;
		if (out_load) begin
			value_q  <= res_q;
			status_q <= stat_q;
			count_q  <= n_q;
		end
	end

	always_comb begin
		state_d  = state_q;
		op_d     = op_q;
		xv_d     = xv_q;
		yv_d     = yv_q;
		n_d      = n_q;
		rd_ptr_d = rd_ptr_q;
		proc_d   = rd_ptr_q[IDX_W-1:0];
		pend_d   = 1'b0;
		found_d  = found_q;
		carry_d  = carry_q;
		res_d    = res_q;
		stat_d   = stat_q;
		we       = 1'b0;
		waddr    = '0;
		wdata    = '0;
		out_load = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					op_d     = op_t'(cmd.op);
					xv_d     = cmd.x_value;
					yv_d     = cmd.y_value;
					rd_ptr_d = '0;
					found_d  = 1'b0;
					res_d    = '0;
					stat_d   = STAT_OK;
					case (cmd.op) inside
						OP_CREATE: state_d = S_FINISH;
						OP_INSERT: state_d = S_WALK;
						OP_DELETE, OP_EVALUATE, OP_MINIMUM, OP_MAXIMUM, OP_TRANSLATE: begin
							if (n_q == '0) begin
								stat_d  = STAT_EMPTY;
								state_d = S_DONE;
							end else begin
								state_d = S_WALK;
							end
						end
						default: state_d = S_DONE;
					endcase
				end
			end

			S_WALK: begin
				// issue the next read
				if (rd_ptr_q < n_q) begin
					pend_d   = 1'b1;
					rd_ptr_d = rd_ptr_q + CNT_W'(1);
				end else if (!pend_q) begin
					state_d = S_FINISH;
				end

				// work on the entry read last cycle
				if (pend_q) begin
					case (op_q)
						OP_INSERT: begin
							if (found_q) begin
								// ripple the displaced entry down one place
								we      = 1'b1;
								waddr   = proc_q;
								wdata   = carry_q;
								carry_d = rdata_q;
							end else if (dx >= xv_q) begin
								if (dx == xv_q) begin
									we      = 1'b1;
									waddr   = proc_q;
									wdata   = {dx, yv_q};
									pend_d  = 1'b0;
									state_d = S_DONE;
								end else if (n_q == CNT_W'(MAX_STEPS)) begin
									stat_d  = STAT_FULL;
									pend_d  = 1'b0;
									state_d = S_DONE;
								end else begin
									we      = 1'b1;
									waddr   = proc_q;
									wdata   = {xv_q, yv_q};
									carry_d = rdata_q;
									found_d = 1'b1;
								end
							end
						end
						OP_DELETE: begin
							if (found_q) begin
								// close the gap
								we    = 1'b1;
								waddr = proc_q - IDX_W'(1);
								wdata = rdata_q;
							end else if (dx == xv_q) begin
								found_d = 1'b1;
							end
						end
						OP_EVALUATE: begin
							if (dx <= xv_q) begin
								res_d   = dy;
								found_d = 1'b1;
							end
						end
						OP_MINIMUM: begin
							if (proc_q == '0 || dy < res_q) begin
								res_d = dy;
							end
						end
						OP_MAXIMUM: begin
							if (proc_q == '0 || dy > res_q) begin
								res_d = dy;
							end
						end
						OP_TRANSLATE: begin
							we    = 1'b1;
							waddr = proc_q;
							wdata = {sat_add(dx, xv_q), sat_add(dy, yv_q)};
						end
						default: ;
					endcase
				end
			end

			S_FINISH: begin
				state_d = S_DONE;
				case (op_q)
					OP_CREATE: begin
						we    = 1'b1;
						waddr = '0;
						wdata = {xv_q, yv_q};
						n_d   = CNT_W'(1);
					end
					OP_INSERT: begin
						// new entry (or the last displaced one) lands at the end
						if (!found_q && n_q == CNT_W'(MAX_STEPS)) begin
							stat_d = STAT_FULL;
						end else begin
							we    = 1'b1;
							waddr = n_q[IDX_W-1:0];
							wdata = found_q ? carry_q : {xv_q, yv_q};
							n_d   = n_q + CNT_W'(1);
						end
					end
					OP_DELETE: begin
						if (found_q) begin
							n_d = n_q - CNT_W'(1);
						end else begin
							stat_d = STAT_MISS;
						end
					end
					OP_EVALUATE: begin
						if (!found_q) begin
							stat_d = STAT_MISS;
							res_d  = '0;
						end
					end
					default: ;
				endcase
			end

			S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end

			default: state_d = S_IDLE;
		endcase
	end

	assign cmd.ready       = (state_q == S_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.value       = value_q;
	assign rsp.status      = status_q;
	assign rsp.entry_count = count_q;

	// count never passes the table size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CNT_W'(MAX_STEPS))
		else $error("breakpoint count above table size");

	// one command at a time: no acceptance right after an acceptance
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> !cmd.ready)
		else $error("command accepted while busy");

	// writes stay within the stored entries plus one append slot
	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> ({1'b0, waddr} <= n_q || op_q == OP_CREATE))
		else $error("memory write beyond stored entries");

	// the count moves by at most one per command other than create
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && op_q != OP_CREATE) |=>
		(n_q == $past(n_q) || n_q == $past(n_q) + CNT_W'(1) ||
		 n_q == $past(n_q) - CNT_W'(1)))
		else $error("count changed by more than one");

endmodule
`default_nettype wire

// ===== verif/ssft_tb_pkg.sv =====
`timescale 1ns / 100ps
package ssft_tb_pkg;
	import ssft_pkg::*;

	// op 7 has no enum member in the design package
	localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] value;
		logic [STAT_W-1:0]            status;
		logic [CNT_W-1:0]             entry_count;
	} table_response_t;

	class step_table_scoreboard;
		logic signed [VALUE_BITS-1:0] point_x [MAX_STEPS];
		logic signed [VALUE_BITS-1:0] point_y [MAX_STEPS];
		int unsigned                  points;
		table_response_t              expected_responses [$];
		int unsigned                  failures;

		function new();
			points   = 0;
			failures = 0;
		endfunction

		function logic signed [VALUE_BITS-1:0] clamp_sum(
			logic signed [VALUE_BITS-1:0] a,
			logic signed [VALUE_BITS-1:0] b
		);
			longint s;
			s = longint'(a) + longint'(b);
			if (s > longint'(VAL_MAX)) return VAL_MAX;
			if (s < longint'(VAL_MIN)) return VAL_MIN;
			return s[VALUE_BITS-1:0];
		endfunction

		// Update the breakpoint list for one accepted command, queue its response.
		function void apply_command(
			logic [OP_W-1:0]              op,
			logic signed [VALUE_BITS-1:0] x,
			logic signed [VALUE_BITS-1:0] y
		);
			table_response_t r;
			int unsigned     i;
			int unsigned     k;
			bit              hit;
			r.value  = '0;
			r.status = STAT_OK;
			hit      = 1'b0;
			if (op == OP_CREATE) begin
				point_x[0] = x;
				point_y[0] = y;
				points     = 1;
			end else if (op == OP_INSERT) begin
				i = 0;
				while (i < points && point_x[i] < x) i++;
				if (i < points && point_x[i] == x) begin
					point_y[i] = y;
				end else if (points >= MAX_STEPS) begin
					r.status = STAT_FULL;
				end else begin
					for (k = points; k > i; k--) begin
						point_x[k] = point_x[k-1];
						point_y[k] = point_y[k-1];
					end
					point_x[i] = x;
					point_y[i] = y;
					points++;
				end
			end else if (op == OP_UNUSED) begin
				// nothing
			end else if (points == 0) begin
				r.status = STAT_EMPTY;
			end else if (op == OP_DELETE) begin
				i = 0;
				while (i < points && point_x[i] != x) i++;
				if (i >= points) begin
					r.status = STAT_MISS;
				end else begin
					for (k = i; k + 1 < points; k++) begin
						point_x[k] = point_x[k+1];
						point_y[k] = point_y[k+1];
					end
					points--;
				end
			end else if (op == OP_EVALUATE) begin
				for (i = 0; i < points; i++) begin
					if (point_x[i] <= x) begin
						r.value = point_y[i];
						hit     = 1'b1;
					end
				end
				if (!hit) r.status = STAT_MISS;
			end else if (op == OP_MINIMUM || op == OP_MAXIMUM) begin
				r.value = point_y[0];
				for (i = 1; i < points; i++) begin
					if (op == OP_MINIMUM ? point_y[i] < r.value : point_y[i] > r.value)
						r.value = point_y[i];
				end
			end else begin
				for (i = 0; i < points; i++) begin
					point_x[i] = clamp_sum(point_x[i], x);
					point_y[i] = clamp_sum(point_y[i], y);
				end
			end
			r.entry_count = points[CNT_W-1:0];
			expected_responses.push_back(r);
		endfunction

		function void check_response(
			logic signed [VALUE_BITS-1:0] value,
			logic [STAT_W-1:0]            status,
			logic [CNT_W-1:0]             entry_count
		);
			table_response_t e;
			if (expected_responses.size() == 0) begin
				$error("response with no command outstanding: value %h status %0d count %0d",
					value, status, entry_count);
				failures++;
				return;
			end
			e = expected_responses.pop_front();
			if (value !== e.value) begin
				$error("value: expected %h, got %h", e.value, value);
				failures++;
			end
			if (status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, status);
				failures++;
			end
			if (entry_count !== e.entry_count) begin
				$error("entry_count: expected %0d, got %0d", e.entry_count, entry_count);
				failures++;
			end
		endfunction
	endclass

endpackage

// ===== verif/tb_sorted_step_function_table_unit.sv =====
`timescale 1ns / 100ps
module tb_sorted_step_function_table_unit;
	import ssft_pkg::*;
	import ssft_tb_pkg::*;

	// stimulus budget and pressure points
	localparam int ITEM_TARGET    = 1000;
	localparam int PAUSE_AT_ITEM  = 500;   // sender waits for a full drain here
	localparam int CALM_FIRST     = 600;   // no idling on either side in this range
	localparam int CALM_LAST      = 800;
	localparam int HOLD_AT_RSP    = 150;   // receiver blocks once after this many
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 80;    // longest command walks all MAX_STEPS entries
	localparam int WATCHDOG_LIMIT = 4000;

	logic clk = 1'b0;
	logic arst_n;

	ssft_cmd_if cmd_if ();
	ssft_rsp_if rsp_if ();

	sorted_step_function_table_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.rsp    (rsp_if)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	step_table_scoreboard sb;
	int  items_sent;
	bit  calm;             // suppresses random idling on both sides
	int  idle_cycles = 0;  // cycles with no transaction on either channel

	// ------------------------------------------------------------------
	// Command side. One call offers one transaction and returns once it
	// is accepted; valid is left high so back-to-back commands don't glitch.
	// ------------------------------------------------------------------
	task automatic send_command(
		input logic [OP_W-1:0]              op,
		input logic signed [VALUE_BITS-1:0] x,
		input logic signed [VALUE_BITS-1:0] y
	);
		int gap;
		if (!calm && $urandom_range(99) < 16) begin
			// mostly short gaps, sometimes one long enough to span a whole walk
			gap = ($urandom_range(3) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 6);
			cmd_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_if.valid   <= 1'b1;
		cmd_if.op      <= op;
		cmd_if.x_value <= x;
		cmd_if.y_value <= y;
		do @(posedge clk); while (!cmd_if.ready);
		sb.apply_command(op, x, y);
		items_sent++;
		calm <= (items_sent >= CALM_FIRST && items_sent < CALM_LAST);
	endtask

	// x picker: an already stored x (hits for delete/replace), extremes,
	// small values near the origin, or anything at all
	function automatic logic signed [VALUE_BITS-1:0] pick_x();
		logic signed [VALUE_BITS-1:0] v;
		int sel;
		sel = $urandom_range(99);
		v   = $urandom;
		if (sel < 40 && sb.points != 0) begin
			v = sb.point_x[$urandom_range(sb.points - 1)];
		end else if (sel < 50) begin
			case ($urandom_range(3))
				0: v = VAL_MAX;
				1: v = VAL_MIN;
				2: v = '0;
				default: v = '1;
			endcase
		end else if (sel < 80) begin
			v = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
		end
		return v;
	endfunction

	function automatic logic signed [VALUE_BITS-1:0] pick_level();
		logic signed [VALUE_BITS-1:0] v;
		v = $urandom;
		case ($urandom_range(9))
			0: v = VAL_MAX;
			1: v = VAL_MIN;
			2, 3, 4: v = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
			default: ;
		endcase
		return v;
	endfunction

	// ------------------------------------------------------------------
	// Directed opening: empty table after reset, extremes, replace,
	// delete hit and miss, query below first, saturating translate that
	// merges x values, and the unused op.
	// ------------------------------------------------------------------
	task automatic run_directed();
		send_command(OP_EVALUATE, 32'sh0001_0000, '0);   // empty table
		send_command(OP_MINIMUM, '0, '0);
		send_command(OP_MAXIMUM, '0, '0);
		send_command(OP_DELETE, '0, '0);
		send_command(OP_TRANSLATE, 32'sh0001_0000, 32'sh0001_0000);
		send_command(OP_UNUSED, '1, '1);
		send_command(OP_INSERT, '0, VAL_MAX);            // insert into empty
		send_command(OP_CREATE, VAL_MIN, VAL_MIN);
		send_command(OP_INSERT, VAL_MAX, VAL_MAX);
		send_command(OP_INSERT, '0, '1);
		send_command(OP_INSERT, '0, 32'sh1234_5678);     // equal x: level replaced
		send_command(OP_EVALUATE, VAL_MIN, '0);          // exact hit on first
		send_command(OP_DELETE, VAL_MIN, '0);
		send_command(OP_EVALUATE, VAL_MIN, '0);          // below first now
		send_command(OP_EVALUATE, VAL_MAX, '0);
		send_command(OP_DELETE, 32'sh0000_0005, '0);     // miss
		send_command(OP_MINIMUM, '0, '0);
		send_command(OP_MAXIMUM, '0, '0);
		send_command(OP_TRANSLATE, VAL_MAX, VAL_MAX);    // both x clamp to max
		send_command(OP_EVALUATE, VAL_MAX, '0);          // takes the last duplicate
		send_command(OP_INSERT, VAL_MAX, 32'sh0000_0001);// replaces the first one
		send_command(OP_DELETE, VAL_MAX, '0);            // removes the first one
		send_command(OP_TRANSLATE, VAL_MIN, VAL_MIN);
		send_command(OP_UNUSED, '0, '0);
		send_command(OP_MAXIMUM, '0, '0);
	endtask

	// create, then keep inserting, often past capacity, so the full case shows up
	task automatic run_fill();
		int n;
		send_command(OP_CREATE, pick_x(), pick_level());
		n = $urandom_range(60, 75);
		repeat (n) send_command(OP_INSERT, $urandom, pick_level());
		send_command(OP_INSERT, $urandom, pick_level());
		send_command(OP_MINIMUM, '0, '0);
		send_command(OP_MAXIMUM, '0, '0);
		send_command(OP_EVALUATE, pick_x(), '0);
		send_command(OP_TRANSLATE, pick_x(), pick_level());
		send_command(OP_EVALUATE, pick_x(), '0);
	endtask

	// well-formed traffic with random content, weighted toward insert/evaluate
	task automatic run_mixed();
		int n;
		int sel;
		send_command(OP_CREATE, pick_x(), pick_level());
		n = $urandom_range(10, 30);
		repeat (n) begin
			sel = $urandom_range(99);
			if (sel < 32)      send_command(OP_INSERT, pick_x(), pick_level());
			else if (sel < 48) send_command(OP_DELETE, pick_x(), pick_level());
			else if (sel < 72) send_command(OP_EVALUATE, pick_x(), pick_level());
			else if (sel < 78) send_command(OP_MINIMUM, pick_x(), pick_level());
			else if (sel < 84) send_command(OP_MAXIMUM, pick_x(), pick_level());
			else if (sel < 93) send_command(OP_TRANSLATE, pick_x(), pick_level());
			else if (sel < 97) send_command(OP_CREATE, pick_x(), pick_level());
			else               send_command(OP_UNUSED, $urandom, $urandom);
		end
	endtask

	// delete down to nothing, then poke every command but create at the empty table
	task automatic run_empty();
		int n;
		send_command(OP_CREATE, pick_x(), pick_level());
		n = $urandom_range(0, 5);
		repeat (n) send_command(OP_INSERT, pick_x(), pick_level());
		while (sb.points != 0)
			send_command(OP_DELETE, sb.point_x[$urandom_range(sb.points - 1)], pick_level());
		send_command(OP_EVALUATE, pick_x(), pick_level());
		send_command(OP_MINIMUM, pick_x(), pick_level());
		send_command(OP_MAXIMUM, pick_x(), pick_level());
		send_command(OP_TRANSLATE, pick_x(), pick_level());
		send_command(OP_DELETE, pick_x(), pick_level());
		send_command(OP_UNUSED, $urandom, $urandom);
		send_command(OP_INSERT, pick_x(), pick_level());
	endtask

	// shift hard into a rail so several x values collapse together
	task automatic run_saturate();
		int n;
		logic signed [VALUE_BITS-1:0] w;
		send_command(OP_CREATE, $signed($urandom_range(0, 32'h0010_0000)), pick_level());
		n = $urandom_range(3, 8);
		repeat (n) send_command(OP_INSERT, $signed($urandom_range(0, 32'h0010_0000)),
			pick_level());
		w = $urandom_range(1) ? VAL_MAX - $signed($urandom_range(0, 32'h0008_0000))
		                      : VAL_MIN + $signed($urandom_range(0, 32'h0008_0000));
		send_command(OP_TRANSLATE, w, $urandom);
		n = $urandom_range(4, 10);
		repeat (n) begin
			case ($urandom_range(5))
				0: send_command(OP_EVALUATE, VAL_MAX, '0);
				1: send_command(OP_EVALUATE, pick_x(), '0);
				2: send_command(OP_INSERT, pick_x(), pick_level());
				3: send_command(OP_DELETE, pick_x(), '0);
				4: send_command(OP_MINIMUM, '0, '0);
				default: send_command(OP_TRANSLATE, pick_x(), pick_level());
			endcase
		end
	endtask

	// raw noise on every field, op 7 included
	task automatic run_noise();
		repeat (8) send_command(OP_W'($urandom_range(0, 7)), $urandom, $urandom);
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		bit paused;
		bit leftover;
		sb             = new();
		items_sent     = 0;
		paused         = 1'b0;
		calm           <= 1'b0;
		arst_n         <= 1'b0;
		cmd_if.valid   <= 1'b0;
		cmd_if.op      <= '0;
		cmd_if.x_value <= '0;
		cmd_if.y_value <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		while (items_sent < ITEM_TARGET) begin
			if (!paused && items_sent >= PAUSE_AT_ITEM) begin
				// sender goes quiet until the block has answered everything
				paused = 1'b1;
				cmd_if.valid <= 1'b0;
				do @(posedge clk); while (sb.expected_responses.size() != 0);
			end
			case ($urandom_range(9))
				0, 1: run_fill();
				2, 3, 4, 5, 6: run_mixed();
				7: run_empty();
				8: run_saturate();
				default: run_noise();
			endcase
		end
		cmd_if.valid <= 1'b0;

		while (sb.expected_responses.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		leftover = (sb.expected_responses.size() != 0);
		if (leftover) $error("%0d responses never arrived", sb.expected_responses.size());
		if (sb.failures == 0 && !leftover) begin
			$display("tb_sorted_step_function_table_unit passed");
		end else begin
			$display("tb_sorted_step_function_table_unit failed");
		end
		$finish;
	end

	// ------------------------------------------------------------------
	// Response side: sample the transaction first, then pick ready for the
	// next cycle. One long block-out fills the unit and backs up commands.
	// ------------------------------------------------------------------
	int  responses_seen = 0;
	int  hold_left      = 0;
	bit  hold_done      = 1'b0;

	always @(posedge clk) begin
		if (rsp_if.valid && rsp_if.ready) begin
			sb.check_response(rsp_if.value, rsp_if.status, rsp_if.entry_count);
			responses_seen++;
		end
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			rsp_if.ready <= 1'b0;
		end else if (!hold_done && responses_seen >= HOLD_AT_RSP) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= calm || ($urandom_range(99) >= 16);
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: too long without a transaction on either channel
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_sorted_step_function_table_unit failed");
			$finish;
		end
	end

endmodule

// ===== sim.f =====
src/ssft_pkg.sv
src/ssft_if.sv
src/sorted_step_function_table_unit.sv
verif/ssft_tb_pkg.sv
verif/tb_sorted_step_function_table_unit.sv
